/* hdl/assert_macros.svh */
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define SMX_ASSERT_NOW(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset
`define SMX_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* hdl/smx_pkg.sv */
// Package: types and constants of the softmax vector normalizer
`timescale 1ns / 1ps
package smx_pkg;

  localparam int PROB_W      = 16;
  localparam int VLEN_W      = 7;
  localparam int EXP_W       = 17;   // exp value, Q1.16, up to 1.0
  localparam int EXP_STEPS   = 12;   // one step per bit of the difference
  localparam int EXP_CUT_SH  = 12;   // difference of 16.0 or more gives zero
  localparam int EXP_P_W     = 33;   // running product, Q1.32
  localparam logic [VLEN_W-1:0] VLEN_RESET = 7'd10;
  localparam logic [31:0] EXP_C0 = 32'd4278222805;  // exp(-1/256), Q0.32

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SUM_RD,
    ST_SUM_GO,
    ST_SUM_WAIT,
    ST_DIV_RD,
    ST_DIV_GO,
    ST_DIV_WAIT
  } smx_state_e;

  // Square the constant k times with rounding, evaluated at elaboration
  function automatic logic [31:0] exp_c(input int k);
    logic [63:0] c;
    c = 64'(EXP_C0);
    for (int j = 0; j < k; j++) begin
      c = (c * c + 64'h8000_0000) >> 32;
    end
    return c[31:0];
  endfunction

  localparam logic [31:0] EXP_C [EXP_STEPS] = '{
    exp_c(0), exp_c(1), exp_c(2), exp_c(3), exp_c(4), exp_c(5),
    exp_c(6), exp_c(7), exp_c(8), exp_c(9), exp_c(10), exp_c(11)
  };

endpackage

/* hdl/smx_if.sv */
// Channel interfaces: score input, probability output, length configuration
`timescale 1ns / 1ps
interface smx_in_if #(parameter int SW = 16);
  logic          valid;
  logic          ready;
  logic [SW-1:0] score;
  modport source (output valid, output score, input ready);
  modport sink   (input valid, input score, output ready);
endinterface

interface smx_out_if #(parameter int IW = 6);
  import smx_pkg::*;
  logic              valid;
  logic              ready;
  logic [PROB_W-1:0] probability;
  logic [IW-1:0]     element_index;
  logic              last;
  modport source (output valid, output probability, output element_index, output last,
                  input ready);
  modport sink   (input valid, input probability, input element_index, input last,
                  output ready);
endinterface

interface smx_cfg_if;
  import smx_pkg::*;
  logic              valid;
  logic              ready;
  logic [VLEN_W-1:0] vector_length;
  modport source (output valid, output vector_length, input ready);
  modport sink   (input valid, input vector_length, output ready);
endinterface

/* hdl/smx_exp.sv */
// Iterative exp(-d/256): one rounded multiply per difference bit
`timescale 1ns / 1ps
module smx_exp #(
  parameter int DW = 17
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [DW-1:0]            diff_i,
  output logic                     valid_o,
  output logic [smx_pkg::EXP_W-1:0] exp_o
);
  import smx_pkg::*;

  localparam int XW = (DW > EXP_STEPS) ? DW : EXP_STEPS;

  logic                 busy_q, busy_d, valid_q, valid_d, cut_q, cut_d;
  logic [3:0]           cnt_q, cnt_d;
  logic [EXP_STEPS-1:0] d_q, d_d;
  logic [EXP_P_W-1:0]   p_q, p_d;
  logic [XW-1:0]        diff_x;
  logic [64:0]          prod;
  logic [64:0]          rnd;
  logic [EXP_P_W-1:0]   fin;

  assign diff_x = XW'(diff_i);
  assign prod   = 65'(p_q) * 65'(EXP_C[cnt_q]);
  assign rnd    = prod + (65'(1) << 31);

  // Load on start, then step through the difference bits
  always_comb begin
    busy_d  = busy_q;
    valid_d = valid_q;
    cut_d   = cut_q;
    cnt_d   = cnt_q;
    d_d     = d_q;
    p_d     = p_q;
    if (start_i) begin
      busy_d  = 1'b1;
      valid_d = 1'b0;
      cut_d   = |(diff_x >> EXP_CUT_SH);
      cnt_d   = '0;
      d_d     = diff_x[EXP_STEPS-1:0];
      p_d     = EXP_P_W'(1) << 32;
    end else if (busy_q) begin
      if (d_q[cnt_q]) begin
        p_d = EXP_P_W'(rnd >> 32);
      end
      if (cnt_q == 4'(EXP_STEPS - 1)) begin
        busy_d  = 1'b0;
        valid_d = 1'b1;
      end else begin
        cnt_d = cnt_q + 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      busy_q  <= busy_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cut_q <= cut_d;
    cnt_q <= cnt_d;
    d_q   <= d_d;
    p_q   <= p_d;
  end

  // Round Q1.32 down to Q1.16
  assign fin     = p_q + EXP_P_W'(1 << 15);
  assign valid_o = valid_q;
  assign exp_o   = cut_q ? '0 : EXP_W'(fin >> 16);

endmodule

/* hdl/smx_div.sv */
// Restoring divider: rounded (e * 2^16) / sum, one quotient bit per cycle
`timescale 1ns / 1ps
module smx_div #(
  parameter int SUMW = 23
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [smx_pkg::EXP_W-1:0] exp_i,
  input  logic [SUMW-1:0]           sum_i,
  output logic                      valid_o,
  output logic [smx_pkg::PROB_W-1:0] prob_o
);
  import smx_pkg::*;

  localparam int QW   = EXP_W;
  localparam int NUMW = ((SUMW > 33) ? SUMW : 33) + 1;
  localparam int RW   = SUMW + 1;

  logic            busy_q, busy_d, valid_q, valid_d, zero_q, zero_d;
  logic [4:0]      cnt_q, cnt_d;
  logic [RW-1:0]   rem_q, rem_d;
  logic [QW-1:0]   lo_q, lo_d, quo_q, quo_d;
  logic [SUMW-1:0] den_q, den_d;
  logic [NUMW-1:0] num;
  logic [RW-1:0]   trial;

  assign num   = (NUMW'(exp_i) << 16) + NUMW'(sum_i >> 1);
  assign trial = {rem_q[RW-2:0], lo_q[QW-1]};

  // Shift one numerator bit into the remainder per step
  always_comb begin
    busy_d  = busy_q;
    valid_d = valid_q;
    zero_d  = zero_q;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    lo_d    = lo_q;
    quo_d   = quo_q;
    den_d   = den_q;
    if (start_i) begin
      busy_d  = 1'b1;
      valid_d = 1'b0;
      zero_d  = (sum_i == '0);
      cnt_d   = '0;
      rem_d   = RW'(num >> QW);
      lo_d    = num[QW-1:0];
      quo_d   = '0;
      den_d   = sum_i;
    end else if (busy_q) begin
      lo_d = lo_q << 1;
      if (trial >= RW'(den_q)) begin
        rem_d = trial - RW'(den_q);
        quo_d = {quo_q[QW-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[QW-2:0], 1'b0};
      end
      if (cnt_q == 5'(QW - 1)) begin
        busy_d  = 1'b0;
        valid_d = 1'b1;
      end else begin
        cnt_d = cnt_q + 5'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      busy_q  <= busy_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    zero_q <= zero_d;
    cnt_q  <= cnt_d;
    rem_q  <= rem_d;
    lo_q   <= lo_d;
    quo_q  <= quo_d;
    den_q  <= den_d;
  end

  // Saturate 1.0 to the largest code
  assign valid_o = valid_q;
  assign prob_o  = zero_q ? '0 :
                   (quo_q[QW-1] ? {PROB_W{1'b1}} : quo_q[PROB_W-1:0]);

endmodule

/* hdl/softmax_vector_normalize_top.sv */
// Top level: max-subtracted softmax over vectors of signed Q8.8 scores
`timescale 1ns / 1ps
// While the block is loading, scores are taken one per cycle into the score
// memory and the running maximum is tracked. The score that completes a vector
// (vector_length, where 0 acts as 1 and values above MAX_LEN act as MAX_LEN)
// closes the input; the block then makes two passes over the memory. The sum
// pass reads each score, runs the shared 12-step exponential unit and stores
// the result in the exp memory. The emit pass reads each exp value back and
// runs the 17-step restoring divider, and waits on any output stall. Input
// reopens as soon as the last probability is in the output register.
module softmax_vector_normalize_top #(
  parameter int MAX_LEN     = 64,
  parameter int SCORE_WIDTH = 16
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  smx_cfg_if.sink  cfg_chan,
  smx_in_if.sink   score_chan,
  smx_out_if.source prob_chan
);
  import smx_pkg::*;

  localparam int SW   = SCORE_WIDTH;
  localparam int AW   = $clog2(MAX_LEN);
  localparam int LW   = $clog2(MAX_LEN + 1);
  localparam int CW   = (LW > VLEN_W) ? LW : VLEN_W;
  localparam int SUMW = $clog2(MAX_LEN) + EXP_W;

  smx_state_e state_q, state_d;

  logic [VLEN_W-1:0]   vlen_q;
  logic [LW-1:0]       fill_q, fill_d, n_q, n_d, eff_len;
  logic [CW-1:0]       vlen_x;
  logic [AW-1:0]       idx_q, idx_d;
  logic signed [SW-1:0] max_q, max_d, in_score, rd_score_q;
  logic [SUMW-1:0]     sum_q, sum_d;
  logic [EXP_W-1:0]    rd_exp_q, exp_val;
  logic signed [SW:0]  diff;
  logic                exp_start, exp_valid, div_start, div_valid;
  logic [PROB_W-1:0]   div_prob;
  logic                in_xfer, out_xfer, idx_last, emit;
  logic                ov_q, ov_d, last_q, last_d;
  logic [PROB_W-1:0]   prob_q, prob_d;
  logic [AW-1:0]       oidx_q, oidx_d;

  logic [SW-1:0]    score_mem [MAX_LEN];
  logic [EXP_W-1:0] exp_mem   [MAX_LEN];

  // Configuration register
  assign cfg_chan.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vlen_q <= VLEN_RESET;
    end else if (cfg_chan.valid) begin
      vlen_q <= cfg_chan.vector_length;
    end
  end

  // Clamp the length to 1..MAX_LEN
  assign vlen_x  = CW'(vlen_q);
  assign eff_len = (vlen_x == '0) ? LW'(1) :
                   ((vlen_x > CW'(MAX_LEN)) ? LW'(MAX_LEN) : LW'(vlen_x));

  assign in_score        = $signed(SW'(score_chan.score));
  assign score_chan.ready = (state_q == ST_LOAD);
  assign in_xfer         = score_chan.valid && score_chan.ready;
  assign out_xfer        = ov_q && prob_chan.ready;
  assign idx_last        = (LW'(idx_q) == n_q - LW'(1));
  assign emit            = (state_q == ST_DIV_WAIT) && div_valid && (!ov_q || prob_chan.ready);
  assign diff            = {max_q[SW-1], max_q} - {rd_score_q[SW-1], rd_score_q};

  // Memories: one write and one registered read each
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      score_mem[fill_q[AW-1:0]] <= SW'(in_score);
    end
    rd_score_q <= $signed(score_mem[idx_q]);
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_SUM_WAIT && exp_valid) begin
      exp_mem[idx_q] <= exp_val;
    end
    rd_exp_q <= exp_mem[idx_q];
  end

  // Shared units
  assign exp_start = (state_q == ST_SUM_GO);
  assign div_start = (state_q == ST_DIV_GO);

  smx_exp #(.DW(SW + 1)) u_exp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (exp_start),
    .diff_i  ($unsigned(diff)),
    .valid_o (exp_valid),
    .exp_o   (exp_val)
  );

  smx_div #(.SUMW(SUMW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .exp_i   (rd_exp_q),
    .sum_i   (sum_q),
    .valid_o (div_valid),
    .prob_o  (div_prob)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_LOAD: begin
        if (in_xfer && (fill_q + LW'(1) >= eff_len)) begin
          state_d = ST_SUM_RD;
        end
      end
      ST_SUM_RD:   state_d = ST_SUM_GO;
      ST_SUM_GO:   state_d = ST_SUM_WAIT;
      ST_SUM_WAIT: begin
        if (exp_valid) begin
          state_d = idx_last ? ST_DIV_RD : ST_SUM_RD;
        end
      end
      ST_DIV_RD:   state_d = ST_DIV_GO;
      ST_DIV_GO:   state_d = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (emit) begin
          state_d = idx_last ? ST_LOAD : ST_DIV_RD;
        end
      end
      default:     state_d = ST_LOAD;
    endcase
  end

  // Datapath and output register updates
  always_comb begin
    fill_d = fill_q;
    n_d    = n_q;
    idx_d  = idx_q;
    max_d  = max_q;
    sum_d  = sum_q;
    ov_d   = ov_q;
    prob_d = prob_q;
    oidx_d = oidx_q;
    last_d = last_q;
    if (out_xfer) begin
      ov_d = 1'b0;
    end
    unique case (state_q)
      ST_LOAD: begin
        if (in_xfer) begin
          fill_d = fill_q + LW'(1);
          if (in_score > max_q) begin
            max_d = in_score;
          end
          if (fill_q + LW'(1) >= eff_len) begin
            n_d    = fill_q + LW'(1);
            fill_d = '0;
            idx_d  = '0;
            sum_d  = '0;
          end
        end
      end
      ST_SUM_WAIT: begin
        if (exp_valid) begin
          sum_d = sum_q + SUMW'(exp_val);
          idx_d = idx_last ? '0 : idx_q + AW'(1);
        end
      end
      ST_DIV_WAIT: begin
        if (emit) begin
          ov_d   = 1'b1;
          prob_d = div_prob;
          oidx_d = idx_q;
          last_d = idx_last;
          idx_d  = idx_q + AW'(1);
          if (idx_last) begin
            max_d = {1'b1, {(SW-1){1'b0}}};
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      fill_q  <= '0;
      max_q   <= {1'b1, {(SW-1){1'b0}}};
      sum_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      max_q   <= max_d;
      sum_q   <= sum_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q    <= n_d;
    idx_q  <= idx_d;
    prob_q <= prob_d;
    oidx_q <= oidx_d;
    last_q <= last_d;
  end

  assign prob_chan.valid         = ov_q;
  assign prob_chan.probability   = prob_q;
  assign prob_chan.element_index = oidx_q;
  assign prob_chan.last          = last_q;

endmodule

/* hdl/smx_checker.sv */
// Port checker for the softmax normalizer, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"
module smx_checker #(
  parameter int IW = 6
) (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          out_valid_i,
  input logic          out_ready_i,
  input logic [15:0]   prob_i,
  input logic [IW-1:0] index_i,
  input logic          last_i
);

  // Hold a stalled result
  `SMX_ASSERT_NEXT(a_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(prob_i) && $stable(index_i))

  // Step the element index within a vector
  `SMX_ASSERT_NEXT(a_step, clk_i, rst_ni, out_valid_i && out_ready_i && !last_i, !out_valid_i || (index_i == IW'($past(index_i) + 1'b1)))

  // Restart the index after the last element
  `SMX_ASSERT_NEXT(a_restart, clk_i, rst_ni, out_valid_i && out_ready_i && last_i, !out_valid_i || (index_i == '0))

  // A one-element vector saturates to full scale
  `SMX_ASSERT_NOW(a_single, clk_i, rst_ni, out_valid_i && last_i && (index_i == '0), prob_i == 16'hFFFF)

endmodule

bind softmax_vector_normalize_top smx_checker #(.IW($clog2(MAX_LEN))) u_smx_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (prob_chan.valid),
  .out_ready_i (prob_chan.ready),
  .prob_i      (prob_chan.probability),
  .index_i     (prob_chan.element_index),
  .last_i      (prob_chan.last)
);
